// File: hdl/ansi_text_console_engine_defines.svh
// assertion macros shared by the console engine modules
`ifndef ANSI_TEXT_CONSOLE_ENGINE_DEFINES_SVH
`define ANSI_TEXT_CONSOLE_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF

// property that must hold at every clock edge outside reset
`define ATE_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// property whose consequent must hold in the cycle after its antecedent
`define ATE_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`else

`define ATE_ASSERT(lbl, clk, rstn, prop, msg)
`define ATE_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)

`endif

`endif

// File: hdl/ate_pkg.sv
// shared types, constants and helper functions of the text console engine
`timescale 1ns / 1ps

package ate_pkg;

    // screen limits and parser depth
    localparam int MAX_COLS       = 128;
    localparam int MAX_ROWS       = 64;
    localparam int NUM_PARAMS_DEF = 3;

    // field widths
    localparam int COLS_W   = 8;
    localparam int ROWS_W   = 7;
    localparam int CCOL_W   = 7;
    localparam int CROW_W   = 6;
    localparam int ACT_W    = 3;
    localparam int BYTE_W   = 8;
    localparam int DATA_W   = 48;
    localparam int ADDR_W   = 3;
    localparam int APB_W    = 32;

    // register indexes, selected by paddr[2]
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    // result actions
    localparam logic [ACT_W-1:0] ACT_CURSOR = 3'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_SCROLL = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_ERASE  = 3'd4;

    // byte codes
    localparam logic [7:0] CH_BS     = 8'd8;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_ESC    = 8'd27;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;

    // final bytes of a control sequence
    localparam logic [7:0] FIN_UP    = 8'h41;  // A
    localparam logic [7:0] FIN_DOWN  = 8'h42;  // B
    localparam logic [7:0] FIN_RIGHT = 8'h43;  // C
    localparam logic [7:0] FIN_LEFT  = 8'h44;  // D
    localparam logic [7:0] FIN_POS   = 8'h48;  // H
    localparam logic [7:0] FIN_CLEAR = 8'h4A;  // J
    localparam logic [7:0] FIN_ERASE = 8'h4B;  // K
    localparam logic [7:0] FIN_POS_F = 8'h66;  // f
    localparam logic [7:0] FIN_SGR   = 8'h6D;  // m
    localparam logic [7:0] FIN_SAVE  = 8'h73;  // s
    localparam logic [7:0] FIN_REST  = 8'h75;  // u

    // attribute handling
    localparam logic [7:0] ATTR_RESET  = 8'h07;
    localparam logic [7:0] ATTR_COLOUR = 8'h77;
    localparam logic [7:0] ATTR_BRIGHT = 8'h08;
    localparam logic [7:0] ATTR_BLINK  = 8'h80;
    localparam logic [7:0] TAB_MASK    = ~8'd3;
    localparam logic [7:0] SGR_RESET   = 8'd0;
    localparam logic [7:0] SGR_BOLD    = 8'd1;
    localparam logic [7:0] SGR_BLINK   = 8'd5;
    localparam logic [7:0] SGR_REVERSE = 8'd7;
    localparam logic [7:0] SGR_FG_LO   = 8'd30;
    localparam logic [7:0] SGR_FG_HI   = 8'd37;
    localparam logic [7:0] SGR_BG_LO   = 8'd40;
    localparam logic [7:0] SGR_BG_HI   = 8'd47;

    // one screen command
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [CROW_W-1:0] row;
        logic [CCOL_W-1:0] col;
        logic [7:0]        glyph;
        logic [7:0]        attr;
    } res_t;

    // all results of one input byte, with the cursor left after it
    typedef struct packed {
        res_t              r0;
        res_t              r1;
        logic              two;
        logic [CCOL_W-1:0] cur_col;
        logic [CROW_W-1:0] cur_row;
    } pair_t;

    // screen size and the pulse that follows a size write
    typedef struct packed {
        logic [COLS_W-1:0] columns;
        logic [ROWS_W-1:0] rows;
        logic              resize;
    } cfg_t;

    // ansi colour number to display colour bits
    function automatic logic [2:0] ate_colour(input logic [2:0] c);
        logic [2:0] r;
        case (c)
            3'd0:    r = 3'd0;
            3'd1:    r = 3'd4;
            3'd2:    r = 3'd2;
            3'd3:    r = 3'd6;
            3'd4:    r = 3'd1;
            3'd5:    r = 3'd5;
            3'd6:    r = 3'd3;
            default: r = 3'd7;
        endcase
        return r;
    endfunction

    // one sgr parameter applied to the attribute
    function automatic logic [7:0] ate_sgr(input logic [7:0] a, input logic [7:0] v);
        logic [7:0] r;
        logic [7:0] off;
        r   = a;
        off = 8'd0;
        if (v == SGR_RESET) begin
            r = a & ATTR_COLOUR;
        end else if (v == SGR_BOLD) begin
            r = a | ATTR_BRIGHT;
        end else if (v == SGR_BLINK) begin
            r = a | ATTR_BLINK;
        end else if (v == SGR_REVERSE) begin
            r = {a[7], a[2:0], a[3], a[6:4]};
        end else if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
            off = v - SGR_FG_LO;
            r   = {a[7:4], 1'b0, ate_colour(off[2:0])};
        end else if (v >= SGR_BG_LO && v <= SGR_BG_HI) begin
            off = v - SGR_BG_LO;
            r   = {1'b0, ate_colour(off[2:0]), a[3:0]};
        end
        return r;
    endfunction

endpackage

// File: hdl/ate_regs.sv
// apb register block holding the screen width and height
`timescale 1ns / 1ps

module ate_regs import ate_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [COLS_W-1:0] columns_reg;
    logic [COLS_W-1:0] columns_next;
    logic [ROWS_W-1:0] rows_reg;
    logic [ROWS_W-1:0] rows_next;
    logic              resize_reg;
    logic              wr_en;
    logic [COLS_W-1:0] wr_cols;
    logic [ROWS_W-1:0] wr_rows;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // written values clamped into the supported screen size
    assign wr_cols = pwdata[COLS_W-1:0];
    assign wr_rows = pwdata[ROWS_W-1:0];

    always_comb begin
        columns_next = columns_reg;
        rows_next    = rows_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_COLUMNS: begin
                    if (wr_cols == '0) begin
                        columns_next = COLS_W'(1);
                    end else if (wr_cols > COLS_W'(MAX_COLS)) begin
                        columns_next = COLS_W'(MAX_COLS);
                    end else begin
                        columns_next = wr_cols;
                    end
                end
                REG_ROWS: begin
                    if (wr_rows == '0) begin
                        rows_next = ROWS_W'(1);
                    end else if (wr_rows > ROWS_W'(MAX_ROWS)) begin
                        rows_next = ROWS_W'(MAX_ROWS);
                    end else begin
                        rows_next = wr_rows;
                    end
                end
            endcase
        end
    end

    // register update and resize pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= COLS_W'(80);
            rows_reg    <= ROWS_W'(25);
            resize_reg  <= 1'b0;
        end else begin
            columns_reg <= columns_next;
            rows_reg    <= rows_next;
            resize_reg  <= wr_en;
        end
    end

    // read back
    always_comb begin
        unique case (paddr[2])
            REG_COLUMNS: prdata = {{(APB_W-COLS_W){1'b0}}, columns_reg};
            REG_ROWS:    prdata = {{(APB_W-ROWS_W){1'b0}}, rows_reg};
        endcase
    end

    assign cfg.columns = columns_reg;
    assign cfg.rows    = rows_reg;
    assign cfg.resize  = resize_reg;

endmodule

// File: hdl/ate_core.sv
// input register, escape parser and cursor logic producing the results of one byte
`timescale 1ns / 1ps
`include "ansi_text_console_engine_defines.svh"

module ate_core import ate_pkg::*; #(
    parameter int NUM_PARAMS = NUM_PARAMS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  cfg_t              cfg,
    input  logic              room,
    output logic              push,
    output pair_t             pair_out
);

    localparam int IDX_W  = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
    localparam int P1_IDX = 1 % NUM_PARAMS;

    // parser states
    localparam logic [1:0] PS_TEXT  = 2'd0;
    localparam logic [1:0] PS_ESC   = 2'd1;
    localparam logic [1:0] PS_PARAM = 2'd2;

    logic              in_vld_reg;
    logic [7:0]        in_byte_reg;
    logic [CCOL_W-1:0] cur_col_reg, cur_col_next;
    logic [CROW_W-1:0] cur_row_reg, cur_row_next;
    logic [CCOL_W-1:0] saved_col_reg, saved_col_next;
    logic [CROW_W-1:0] saved_row_reg, saved_row_next;
    logic [7:0]        attr_reg, attr_next;
    logic [1:0]        pst_reg, pst_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [7:0]        params_reg  [NUM_PARAMS];
    logic [7:0]        params_next [NUM_PARAMS];

    res_t              res0, res1;
    logic [1:0]        n_res;
    logic              text_op, seq_op, adv_row, wrote;
    logic [7:0]        col8, row8, cols_m1, rows_m1, p0, p1, tab_col, sel8, diff8;
    logic [7:0]        row8p1, col8p1, a_tmp;
    logic [8:0]        sum9;
    logic [11:0]       acc12;

    // input register
    assign s_tready = !in_vld_reg || room;
    assign push     = in_vld_reg && room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_vld_reg <= 1'b1;
        end else if (push) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    // per-byte decode
    always_comb begin
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        saved_col_next = saved_col_reg;
        saved_row_next = saved_row_reg;
        attr_next      = attr_reg;
        pst_next       = pst_reg;
        idx_next       = idx_reg;
        params_next    = params_reg;
        res0           = '0;
        res1           = '0;
        n_res          = 2'd0;
        text_op        = 1'b0;
        seq_op         = 1'b0;
        adv_row        = 1'b0;
        wrote          = 1'b0;
        col8           = {1'b0, cur_col_reg};
        row8           = {2'b0, cur_row_reg};
        cols_m1        = cfg.columns - 8'd1;
        rows_m1        = {1'b0, cfg.rows - 7'd1};
        p0             = params_reg[0];
        p1             = params_reg[P1_IDX];
        tab_col        = (col8 + 8'd4) & TAB_MASK;
        row8p1         = row8 + 8'd1;
        col8p1         = col8 + 8'd1;
        sel8           = 8'd0;
        diff8          = 8'd0;
        sum9           = 9'd0;
        acc12          = 12'd0;
        a_tmp          = attr_reg;

        if (cfg.resize) begin
            // screen size changed: pull both cursors back onto the screen
            if (col8 >= cfg.columns) cur_col_next = cols_m1[CCOL_W-1:0];
            if (row8 >= {1'b0, cfg.rows}) cur_row_next = rows_m1[CROW_W-1:0];
            if ({1'b0, saved_col_reg} >= cfg.columns) saved_col_next = cols_m1[CCOL_W-1:0];
            if ({2'b0, saved_row_reg} >= {1'b0, cfg.rows}) begin
                saved_row_next = rows_m1[CROW_W-1:0];
            end
        end else if (push) begin
            // parser
            unique case (pst_reg)
                PS_ESC: begin
                    if (in_byte_reg == CH_LBRACK) begin
                        pst_next       = PS_PARAM;
                        idx_next       = '0;
                        params_next[0] = 8'd0;
                    end else begin
                        text_op = 1'b1;
                    end
                end
                PS_PARAM: begin
                    if (in_byte_reg >= CH_0 && in_byte_reg <= CH_9) begin
                        diff8 = in_byte_reg - CH_0;
                        acc12 = {4'b0, params_reg[idx_reg]} * 12'd10 + {8'b0, diff8[3:0]};
                        params_next[idx_reg] = (acc12 > 12'd255) ? 8'hFF : acc12[7:0];
                    end else if (in_byte_reg == CH_SEMI && int'(idx_reg) + 1 < NUM_PARAMS) begin
                        idx_next              = idx_reg + 1'b1;
                        params_next[idx_next] = 8'd0;
                    end else begin
                        pst_next = PS_TEXT;
                        seq_op   = 1'b1;
                    end
                end
                default: begin
                    text_op = 1'b1;
                end
            endcase

            // text bytes
            if (text_op) begin
                pst_next = PS_TEXT;
                unique case (in_byte_reg)
                    CH_ESC: pst_next = PS_ESC;
                    CH_TAB: begin
                        if (tab_col >= cfg.columns) begin
                            cur_col_next = '0;
                            adv_row      = 1'b1;
                        end else begin
                            cur_col_next = tab_col[CCOL_W-1:0];
                        end
                    end
                    CH_LF: begin
                        cur_col_next = '0;
                        adv_row      = 1'b1;
                    end
                    CH_BS: begin
                        if (cur_col_reg != '0) cur_col_next = cur_col_reg - 1'b1;
                    end
                    default: begin
                        res0.action = ACT_WRITE;
                        res0.row    = cur_row_reg;
                        res0.col    = cur_col_reg;
                        res0.glyph  = in_byte_reg;
                        res0.attr   = attr_reg;
                        n_res       = 2'd1;
                        wrote       = 1'b1;
                        if (col8p1 >= cfg.columns) begin
                            cur_col_next = '0;
                            adv_row      = 1'b1;
                        end else begin
                            cur_col_next = col8p1[CCOL_W-1:0];
                        end
                    end
                endcase
            end

            // line feed past the bottom row scrolls
            if (adv_row) begin
                if (row8p1 >= {1'b0, cfg.rows}) begin
                    cur_row_next = rows_m1[CROW_W-1:0];
                    if (wrote) begin
                        res1.action = ACT_SCROLL;
                        res1.row    = rows_m1[CROW_W-1:0];
                        res1.glyph  = CH_SPACE;
                        res1.attr   = attr_reg;
                        n_res       = 2'd2;
                    end else begin
                        res0.action = ACT_SCROLL;
                        res0.row    = rows_m1[CROW_W-1:0];
                        res0.glyph  = CH_SPACE;
                        res0.attr   = attr_reg;
                        n_res       = 2'd1;
                    end
                end else begin
                    cur_row_next = row8p1[CROW_W-1:0];
                end
            end

            // control sequence final byte
            if (seq_op) begin
                unique case (in_byte_reg) inside
                    FIN_POS, FIN_POS_F: begin
                        sel8         = (p0 < rows_m1) ? p0 : rows_m1;
                        cur_row_next = sel8[CROW_W-1:0];
                        if (idx_reg != '0) begin
                            sel8         = (p1 < cols_m1) ? p1 : cols_m1;
                            cur_col_next = sel8[CCOL_W-1:0];
                        end
                    end
                    FIN_UP: begin
                        if (row8 >= p0) begin
                            diff8        = row8 - p0;
                            cur_row_next = diff8[CROW_W-1:0];
                        end
                    end
                    FIN_DOWN: begin
                        sum9         = {1'b0, row8} + {1'b0, p0};
                        cur_row_next = (sum9 < {1'b0, rows_m1}) ? sum9[CROW_W-1:0]
                                                                : rows_m1[CROW_W-1:0];
                    end
                    FIN_RIGHT: begin
                        sum9         = {1'b0, col8} + {1'b0, p0};
                        cur_col_next = (sum9 < {1'b0, cols_m1}) ? sum9[CCOL_W-1:0]
                                                                : cols_m1[CCOL_W-1:0];
                    end
                    FIN_LEFT: begin
                        if (col8 >= p0) begin
                            diff8        = col8 - p0;
                            cur_col_next = diff8[CCOL_W-1:0];
                        end
                    end
                    FIN_SAVE: begin
                        saved_col_next = cur_col_reg;
                        saved_row_next = cur_row_reg;
                    end
                    FIN_REST: begin
                        cur_col_next = saved_col_reg;
                        cur_row_next = saved_row_reg;
                    end
                    FIN_CLEAR: begin
                        cur_col_next = '0;
                        cur_row_next = '0;
                        res0.action  = ACT_CLEAR;
                        res0.glyph   = CH_SPACE;
                        res0.attr    = attr_reg;
                        n_res        = 2'd1;
                    end
                    FIN_ERASE: begin
                        res0.action = ACT_ERASE;
                        res0.row    = cur_row_reg;
                        res0.col    = cur_col_reg;
                        res0.glyph  = CH_SPACE;
                        res0.attr   = attr_reg;
                        n_res       = 2'd1;
                    end
                    FIN_SGR: begin
                        for (int i = 0; i < NUM_PARAMS; i++) begin
                            if (i <= int'(idx_reg)) a_tmp = ate_sgr(a_tmp, params_reg[i]);
                        end
                        attr_next = a_tmp;
                    end
                    default: begin
                        attr_next = attr_reg;
                    end
                endcase
            end
        end
    end

    // results of this byte; an empty res0 is the cursor-only report
    assign pair_out.r0      = res0;
    assign pair_out.r1      = res1;
    assign pair_out.two     = (n_res == 2'd2);
    assign pair_out.cur_col = cur_col_next;
    assign pair_out.cur_row = cur_row_next;

    // console state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            saved_col_reg <= '0;
            saved_row_reg <= '0;
            attr_reg      <= ATTR_RESET;
            pst_reg       <= PS_TEXT;
            idx_reg       <= '0;
            for (int i = 0; i < NUM_PARAMS; i++) params_reg[i] <= 8'd0;
        end else begin
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            saved_col_reg <= saved_col_next;
            saved_row_reg <= saved_row_next;
            attr_reg      <= attr_next;
            pst_reg       <= pst_next;
            idx_reg       <= idx_next;
            params_reg    <= params_next;
        end
    end

    // cursors stay on screen except in the cycle that applies a new size
    `ATE_ASSERT(a_cursor_on_screen, aclk, aresetn, cfg.resize || (({1'b0, cur_col_reg} < cfg.columns) && ({2'b0, cur_row_reg} < {1'b0, cfg.rows})), "cursor off screen")
    `ATE_ASSERT(a_saved_on_screen, aclk, aresetn, cfg.resize || (({1'b0, saved_col_reg} < cfg.columns) && ({2'b0, saved_row_reg} < {1'b0, cfg.rows})), "saved cursor off screen")
    `ATE_ASSERT(a_param_slot, aclk, aresetn, int'(idx_reg) < NUM_PARAMS, "parameter slot out of range")

endmodule

// File: hdl/ate_out_buf.sv
// two-entry result buffer that serialises each byte's results onto the master stream
`timescale 1ns / 1ps
`include "ansi_text_console_engine_defines.svh"

module ate_out_buf import ate_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  pair_t             pair_in,
    output logic              room,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,
    output logic              m_tlast
);

    localparam logic [1:0] BUF_FULL = 2'd2;

    pair_t      ent_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       sub_reg;
    pair_t      head;
    res_t       cur_res;
    logic       xfer, pop;

    assign room     = (cnt_reg != BUF_FULL);
    assign head     = ent_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tlast  = !head.two || sub_reg;
    assign cur_res  = sub_reg ? head.r1 : head.r0;
    assign xfer     = m_tvalid && m_tready;
    assign pop      = xfer && m_tlast;

    // result fields, listed from the highest bit down
    assign m_tdata = {{(DATA_W-45){1'b0}}, head.cur_row, head.cur_col, cur_res.attr,
                      cur_res.glyph, cur_res.col, cur_res.row, cur_res.action};

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= pair_in;
        end
    end

    // occupancy
    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // pointers and second-result flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            sub_reg    <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
                sub_reg    <= 1'b0;
            end else if (xfer) begin
                sub_reg <= 1'b1;
            end
        end
    end

    `ATE_ASSERT(a_cnt_range, aclk, aresetn, cnt_reg != 2'd3, "buffer count out of range")
    `ATE_ASSERT(a_ptr_match, aclk, aresetn, (cnt_reg == 2'd1) == (wr_ptr_reg != rd_ptr_reg), "buffer pointers disagree with count")
    `ATE_ASSERT(a_sub_two, aclk, aresetn, !sub_reg || (m_tvalid && head.two), "second result pending without a two-result entry")
    `ATE_ASSERT_NEXT(a_second_follows, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid && m_tlast, "second result did not follow")

endmodule

// File: hdl/ansi_text_console_engine.sv
// Text console engine: turns a byte stream with ANSI escape sequences into
// character-cell screen commands.
//
// Slave stream s_*: one byte per transaction in s_tdata. Master stream m_*:
// one or two screen commands per byte, the last one marked by m_tlast; every
// byte gives at least a cursor-only report. The APB port holds the screen
// width (address 0) and height (address 4); write them only while idle.
//
// An accepted byte waits in the input register; its decoded results are
// stored in the result buffer, which drives them onto m_*. Throughput: one
// byte per cycle while the result buffer has room; a byte that writes the
// bottom-right cell and scrolls gives two results. The byte decode is one
// pass of logic between the input register and a two-entry result buffer.
//
// Reset gives an 80 by 25 screen, cursor and saved cursor at home, grey on
// black and the parser in text mode. When m_tready is low the buffer fills,
// then the input register holds its byte and s_tready drops; nothing is lost.
`timescale 1ns / 1ps

module ansi_text_console_engine import ate_pkg::*; #(
    parameter int NUM_PARAMS = NUM_PARAMS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // slave stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // byte_in
    // master stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // action, row, col, glyph, cell_attr,
                                         // cursor_col, cursor_row, zero pad
    output logic              m_tlast,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    cfg_t  cfg;
    logic  room;
    logic  push;
    pair_t pair;

    // screen size registers
    ate_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // decode and console state
    ate_core #(
        .NUM_PARAMS (NUM_PARAMS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg),
        .room     (room),
        .push     (push),
        .pair_out (pair)
    );

    // result buffer
    ate_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .pair_in  (pair),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: test/testbench.sv
// self-checking testbench for the ansi text console engine
`timescale 1ns / 1ps

module testbench;
    import ate_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PARAM_SLOTS = 3;
    localparam int NUM_SIZES   = 7;
    localparam int SEG_ITEMS   = 225;

    // parser position inside an escape sequence
    typedef enum logic [1:0] {
        PS_TEXT,
        PS_ESC,
        PS_PARAM
    } parse_t;

    // one screen command with the cursor reported beside it
    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [CROW_W-1:0] row;
        logic [CCOL_W-1:0] col;
        logic [7:0]        glyph;
        logic [7:0]        attr;
        logic [CCOL_W-1:0] ccol;
        logic [CROW_W-1:0] crow;
        logic              is_last;
    } cmd_t;

    // ansi colour number to display colour bits
    localparam logic [2:0] COLOUR_MAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

    // console state tracker and store of expected screen commands
    class console_checker;
        logic [COLS_W-1:0] columns;
        logic [ROWS_W-1:0] rows;
        logic [CCOL_W-1:0] cur_col;
        logic [CROW_W-1:0] cur_row;
        logic [CCOL_W-1:0] saved_col;
        logic [CROW_W-1:0] saved_row;
        logic [7:0]        attr;
        parse_t            pstate;
        logic [1:0]        pidx;
        logic [7:0]        prm [PARAM_SLOTS];
        cmd_t              expected_cmds [$];
        cmd_t              byte_cmds [$];
        int                errors;
        int                checked;
        int                n_write;
        int                n_scroll;
        int                n_clear;
        int                n_erase;

        function new();
            errors   = 0;
            checked  = 0;
            n_write  = 0;
            n_scroll = 0;
            n_clear  = 0;
            n_erase  = 0;
            reset_state();
        endfunction

        function void reset_state();
            columns   = 8'd80;
            rows      = 7'd25;
            cur_col   = '0;
            cur_row   = '0;
            saved_col = '0;
            saved_row = '0;
            attr      = ATTR_RESET;
            pstate    = PS_TEXT;
            pidx      = '0;
            foreach (prm[i]) prm[i] = '0;
            expected_cmds.delete();
        endfunction

        function int pending();
            return expected_cmds.size();
        endfunction

        function int lesser(int a, int b);
            return (a < b) ? a : b;
        endfunction

        // screen size write, out-of-range sizes folded in, cursors pulled inside
        function void write_reg(logic idx, logic [31:0] v);
            int n;
            if (idx == REG_COLUMNS) begin
                n = int'(v[7:0]);
                if (n == 0) n = 1;
                else if (n > MAX_COLS) n = MAX_COLS;
                columns = COLS_W'(n);
            end else begin
                n = int'(v[6:0]);
                if (n == 0) n = 1;
                else if (n > MAX_ROWS) n = MAX_ROWS;
                rows = ROWS_W'(n);
            end
            if (cur_col >= columns) cur_col = CCOL_W'(int'(columns) - 1);
            if (cur_row >= rows) cur_row = CROW_W'(int'(rows) - 1);
            if (saved_col >= columns) saved_col = CCOL_W'(int'(columns) - 1);
            if (saved_row >= rows) saved_row = CROW_W'(int'(rows) - 1);
        endfunction

        function void add_cmd(logic [ACT_W-1:0] a, int r, int c, logic [7:0] g);
            cmd_t t;
            t        = '0;
            t.action = a;
            t.row    = CROW_W'(r);
            t.col    = CCOL_W'(c);
            t.glyph  = g;
            t.attr   = attr;
            byte_cmds.push_back(t);
        endfunction

        // line feed, scrolling once the bottom row is passed
        function void next_row();
            if (int'(cur_row) + 1 >= int'(rows)) begin
                cur_row = CROW_W'(int'(rows) - 1);
                add_cmd(ACT_SCROLL, int'(rows) - 1, 0, CH_SPACE);
            end else begin
                cur_row = cur_row + 1'b1;
            end
        endfunction

        // byte outside a control sequence
        function void text_byte(logic [7:0] b);
            int nc;
            case (b)
                CH_ESC: pstate = PS_ESC;
                CH_TAB: begin
                    nc = (int'(cur_col) + 4) & ~3;
                    if (nc >= int'(columns)) begin
                        cur_col = '0;
                        next_row();
                    end else begin
                        cur_col = CCOL_W'(nc);
                    end
                end
                CH_LF: begin
                    cur_col = '0;
                    next_row();
                end
                CH_BS: if (cur_col > 0) cur_col = cur_col - 1'b1;
                default: begin
                    add_cmd(ACT_WRITE, int'(cur_row), int'(cur_col), b);
                    nc = int'(cur_col) + 1;
                    if (nc >= int'(columns)) begin
                        cur_col = '0;
                        next_row();
                    end else begin
                        cur_col = CCOL_W'(nc);
                    end
                end
            endcase
        endfunction

        // accepted input byte: advance the state and queue its commands
        function void predict_byte(logic [7:0] b);
            int         nv;
            int         p0;
            int         cnt;
            int         v;
            logic [7:0] a;
            cmd_t       t;
            byte_cmds.delete();
            case (pstate)
                PS_ESC: begin
                    if (b == CH_LBRACK) begin
                        pstate = PS_PARAM;
                        pidx   = '0;
                        prm[0] = '0;
                    end else begin
                        pstate = PS_TEXT;
                        text_byte(b);
                    end
                end
                PS_PARAM: begin
                    if (b >= CH_0 && b <= CH_9) begin
                        nv = int'(prm[pidx]) * 10 + int'(b) - int'(CH_0);
                        prm[pidx] = (nv > 255) ? 8'd255 : 8'(nv);
                    end else if (b == CH_SEMI && int'(pidx) + 1 < PARAM_SLOTS) begin
                        pidx      = pidx + 1'b1;
                        prm[pidx] = '0;
                    end else begin
                        // final byte of the sequence
                        pstate = PS_TEXT;
                        p0     = int'(prm[0]);
                        cnt    = int'(pidx) + 1;
                        case (b)
                            FIN_POS, FIN_POS_F: begin
                                cur_row = CROW_W'(lesser(p0, int'(rows) - 1));
                                if (cnt > 1) begin
                                    cur_col = CCOL_W'(lesser(int'(prm[1]), int'(columns) - 1));
                                end
                            end
                            FIN_UP: begin
                                if (int'(cur_row) >= p0) cur_row = CROW_W'(int'(cur_row) - p0);
                            end
                            FIN_DOWN: begin
                                cur_row = CROW_W'(lesser(int'(cur_row) + p0, int'(rows) - 1));
                            end
                            FIN_RIGHT: begin
                                cur_col = CCOL_W'(lesser(int'(cur_col) + p0, int'(columns) - 1));
                            end
                            FIN_LEFT: begin
                                if (int'(cur_col) >= p0) cur_col = CCOL_W'(int'(cur_col) - p0);
                            end
                            FIN_SAVE: begin
                                saved_col = cur_col;
                                saved_row = cur_row;
                            end
                            FIN_REST: begin
                                cur_col = saved_col;
                                cur_row = saved_row;
                            end
                            FIN_CLEAR: begin
                                cur_col = '0;
                                cur_row = '0;
                                add_cmd(ACT_CLEAR, 0, 0, CH_SPACE);
                            end
                            FIN_ERASE: add_cmd(ACT_ERASE, int'(cur_row), int'(cur_col), CH_SPACE);
                            FIN_SGR: begin
                                for (int i = 0; i < cnt && i < PARAM_SLOTS; i++) begin
                                    v = int'(prm[i]);
                                    a = attr;
                                    if (v == SGR_RESET) a = a & ATTR_COLOUR;
                                    else if (v == SGR_BOLD) a = a | ATTR_BRIGHT;
                                    else if (v == SGR_BLINK) a = a | ATTR_BLINK;
                                    else if (v == SGR_REVERSE)
                                        a = (a & 8'h88) | ((a & 8'h07) << 4) | ((a >> 4) & 8'h07);
                                    else if (v >= SGR_FG_LO && v <= SGR_FG_HI)
                                        a = (a & 8'hF0) | {5'b0, COLOUR_MAP[v - SGR_FG_LO]};
                                    else if (v >= SGR_BG_LO && v <= SGR_BG_HI)
                                        a = (a & 8'h0F) | {1'b0, COLOUR_MAP[v - SGR_BG_LO], 4'b0};
                                    attr = a;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: text_byte(b);
            endcase

            // a byte with no screen command still reports the cursor
            if (byte_cmds.size() == 0) begin
                t        = '0;
                t.action = ACT_CURSOR;
                byte_cmds.push_back(t);
            end
            foreach (byte_cmds[k]) begin
                t         = byte_cmds[k];
                t.ccol    = cur_col;
                t.crow    = cur_row;
                t.is_last = (k == byte_cmds.size() - 1);
                case (t.action)
                    ACT_WRITE:  n_write++;
                    ACT_SCROLL: n_scroll++;
                    ACT_CLEAR:  n_clear++;
                    ACT_ERASE:  n_erase++;
                    default: ;
                endcase
                expected_cmds.push_back(t);
            end
        endfunction

        function void cmp_field(string name, int exp_v, int got_v);
            if (exp_v != got_v) begin
                errors++;
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v,
                         got_v);
            end
        endfunction

        // accepted result transaction against the oldest expected command
        function void check_command(logic [DATA_W-1:0] d, logic tl);
            cmd_t e;
            checked++;
            if (expected_cmds.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual data 0x%0h last %0b",
                         $time, d, tl);
                return;
            end
            e = expected_cmds.pop_front();
            cmp_field("action", int'(e.action), int'(d[2:0]));
            cmp_field("row", int'(e.row), int'(d[8:3]));
            cmp_field("col", int'(e.col), int'(d[15:9]));
            cmp_field("glyph", int'(e.glyph), int'(d[23:16]));
            cmp_field("cell_attr", int'(e.attr), int'(d[31:24]));
            cmp_field("cursor_col", int'(e.ccol), int'(d[38:32]));
            cmp_field("cursor_row", int'(e.crow), int'(d[44:39]));
            cmp_field("last", int'(e.is_last), int'(tl));
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    console_checker screen = new();
    int             items_sent = 0;
    int             cycle_count = 0;
    bit             src_idle_en = 1'b1;
    bit             snk_idle_en = 1'b1;
    bit             tail_phase = 1'b0;

    ansi_text_console_engine uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, screen.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    // transaction monitor on both streams
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) screen.predict_byte(s_tdata);
        if (aresetn && m_tvalid && m_tready) screen.check_command(m_tdata, m_tlast);
    end

    // result side back-pressure in short bursts
    initial begin
        int stall;
        m_tready = 1'b0;
        stall    = 0;
        forever begin
            @(posedge aclk);
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
                stall = int'($urandom_range(0, 4));
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one byte on the input stream, with an occasional idle burst first
    task automatic send_byte(logic [7:0] b);
        if (src_idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_number(int n);
        string s;
        s = $sformatf("%0d", n);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    task automatic send_text(string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    // apb write: setup then access phase, then back to idle
    task automatic apb_write(logic idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        screen.write_reg(idx, v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // stop sending and let every expected command come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (screen.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic int pick_param();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 999);
            1, 2, 3: return $urandom_range(0, 3);
            default: return $urandom_range(0, int'(screen.columns));
        endcase
    endfunction

    function automatic int pick_sgr();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 7);
            1, 2:    return $urandom_range(SGR_FG_LO, SGR_FG_HI);
            3, 4:    return $urandom_range(SGR_BG_LO, SGR_BG_HI);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic logic [7:0] pick_final();
        case ($urandom_range(0, 10))
            0:       return FIN_POS;
            1:       return FIN_POS_F;
            2:       return FIN_UP;
            3:       return FIN_DOWN;
            4:       return FIN_RIGHT;
            5:       return FIN_LEFT;
            6:       return FIN_SAVE;
            7:       return FIN_REST;
            8:       return FIN_CLEAR;
            9:       return FIN_ERASE;
            default: return FIN_SGR;
        endcase
    endfunction

    // control sequence with nparams parameters, some left empty
    task automatic send_csi(logic [7:0] fin, int nparams);
        send_byte(CH_ESC);
        send_byte(CH_LBRACK);
        for (int i = 0; i < nparams; i++) begin
            if (i > 0) send_byte(CH_SEMI);
            if ($urandom_range(0, 7) != 0) send_number(fin == FIN_SGR ? pick_sgr() : pick_param());
        end
        send_byte(fin);
    endtask

    // one random run of bytes, mostly well-formed sequences
    task automatic random_sequence();
        int kind;
        kind = int'($urandom_range(0, 99));
        if (!tail_phase && $urandom_range(0, 15) == 0) src_idle_en = !src_idle_en;
        if (!tail_phase && $urandom_range(0, 15) == 0) snk_idle_en = !snk_idle_en;
        if (kind < 30) begin
            repeat ($urandom_range(1, 12))
                send_byte(8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(8'h20, 8'h7E)));
        end else if (kind < 45) begin
            case ($urandom_range(0, 2))
                0:       send_byte(CH_TAB);
                1:       send_byte(CH_LF);
                default: send_byte(CH_BS);
            endcase
        end else if (kind < 85) begin
            send_csi(pick_final(), int'($urandom_range(0, PARAM_SLOTS)));
        end else if (kind < 95) begin
            case ($urandom_range(0, 3))
                // escape followed by a random byte
                0: begin
                    send_byte(CH_ESC);
                    send_byte(8'($urandom_range(0, 255)));
                end
                // one parameter too many
                1: send_csi(pick_final(), PARAM_SLOTS + 1);
                // random final byte
                2: send_csi(8'($urandom_range(0, 255)), int'($urandom_range(0, 2)));
                default: begin
                    send_byte(CH_ESC);
                    send_csi(pick_final(), int'($urandom_range(0, 2)));
                end
            endcase
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // screen sizes per phase, extremes and out-of-range values among them
    int cfg_cols [NUM_SIZES] = '{1, 128, 0, 255, 0, 2, 40};
    int cfg_rows [NUM_SIZES] = '{1, 64, 0, 127, 0, 2, 12};

    initial begin
        int c;
        int r;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        screen.reset_state();
        @(posedge aclk);

        // directed: field extremes, controls, saturation and clamping,
        // bottom-right write into a scroll, erase, reverse video, bad escape, clear
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_TAB);
        send_byte(CH_BS);
        send_byte(CH_LF);
        send_byte(CH_ESC);
        send_text("[999;999H");
        send_byte(8'h5A);
        send_byte(CH_ESC);
        send_text("[K");
        send_byte(CH_ESC);
        send_text("[7m");
        send_byte(CH_ESC);
        send_byte(8'h78);
        send_byte(CH_ESC);
        send_text("[J");

        while (items_sent < SEG_ITEMS) random_sequence();

        for (int ph = 0; ph < NUM_SIZES; ph++) begin
            drain();
            c = (cfg_cols[ph] == 0 && ph == 4) ? int'($urandom_range(1, MAX_COLS)) : cfg_cols[ph];
            r = (cfg_rows[ph] == 0 && ph == 4) ? int'($urandom_range(1, MAX_ROWS)) : cfg_rows[ph];
            apb_write(REG_COLUMNS, ($urandom() & 32'hFFFF_FF00) | c);
            apb_write(REG_ROWS, ($urandom() & 32'hFFFF_FF80) | r);
            // last phase runs at full rate on both sides
            if (ph == NUM_SIZES - 1) begin
                tail_phase  = 1'b1;
                src_idle_en = 1'b0;
                snk_idle_en = 1'b0;
            end
            while (items_sent < SEG_ITEMS * (ph + 2)) random_sequence();
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("sent %0d bytes over %0d screen sizes, %0d results checked", items_sent,
                 NUM_SIZES + 1, screen.checked);
        $display("cell writes %0d, scrolls %0d, clears %0d, line erases %0d, mismatches %0d",
                 screen.n_write, screen.n_scroll, screen.n_clear, screen.n_erase, screen.errors);
        if (screen.errors == 0 && screen.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/ate_pkg.sv
hdl/ate_regs.sv
hdl/ate_core.sv
hdl/ate_out_buf.sv
hdl/ansi_text_console_engine.sv
test/testbench.sv
